// ===== hw/rtl/psd_pkg.sv =====
// shared widths and the item bus carried down the root pipeline
// used by psd_front, psd_root_step and point_segment_distance_core
package psd_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned DiffW  = CoordW + 1;
    localparam int unsigned SqW    = 2 * DiffW;
    localparam int unsigned Len2W  = SqW - 1;
    localparam int unsigned DotW   = SqW + 1;
    localparam int unsigned CrAbsW = SqW;
    localparam int unsigned RemW   = 70;
    localparam int unsigned DistW  = 17;
    localparam int unsigned YW     = DistW + Len2W + 1;
    localparam int unsigned RootSteps = DistW;
    localparam int unsigned FrontStages = 5;
    localparam int unsigned Latency = FrontStages + RootSteps;

    typedef struct packed {
        logic              valid;
        logic [RemW-1:0]   rem;
        logic [YW-1:0]     y;
        logic [Len2W-1:0]  c;
        logic [DistW-1:0]  q;
    } t_root_bus;

endpackage

// ===== hw/rtl/point_segment_distance_core.sv =====
// shortest distance from a point to a segment, fully pipelined
// top level; uses psd_pkg, psd_front and psd_root_step
//
// start and the six signed Q12.4 coordinates form one item, taken at any
// rising edge with start high and busy low. busy is held low: the pipe
// takes a new item every cycle and never stalls.
// each item gives one unsigned Q13.4 distance on o_distance, marked by a
// one-cycle o_valid strobe, in order of entry.
// from the accepting edge to the edge that takes the result, an item
// passes five front stages (differences, 16x16 and 17x17 products, sums,
// case select plus split squaring of the cross product, root operands)
// and seventeen root stages, one result bit per stage with a 70-bit
// compare and subtract.
// throughput is one item per cycle.
// reset clears every valid bit; items in flight are dropped.
// the receiver cannot stall, results are simply presented for one cycle.
module point_segment_distance_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [psd_pkg::CoordW-1:0]    i_px,
    input  logic signed [psd_pkg::CoordW-1:0]    i_py,
    input  logic signed [psd_pkg::CoordW-1:0]    i_ax,
    input  logic signed [psd_pkg::CoordW-1:0]    i_ay,
    input  logic signed [psd_pkg::CoordW-1:0]    i_bx,
    input  logic signed [psd_pkg::CoordW-1:0]    i_by_coord,
    output logic                                 o_valid,
    output logic [psd_pkg::DistW-1:0]            o_distance
);
    import psd_pkg::*;

    t_root_bus w_bus [RootSteps+1];

    assign busy = 1'b0;

    psd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_px       (i_px),
        .i_py       (i_py),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_bx       (i_bx),
        .i_by_coord (i_by_coord),
        .o_bus      (w_bus[0])
    );

    // most significant result bit first
    for (genvar g = 0; g < RootSteps; g++) begin : g_root
        psd_root_step #(
            .Bit (RootSteps - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    assign o_valid    = w_bus[RootSteps].valid;
    assign o_distance = w_bus[RootSteps].q;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, Latency))
        else $error("result strobe without an item accepted earlier");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##Latency o_valid)
        else $error("accepted item produced no result");

    a_on_endpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_px == i_ax && i_py == i_ay) |-> ##Latency (o_distance == '0))
        else $error("point on an endpoint gave a nonzero distance");

endmodule

// ===== hw/rtl/psd_front.sv =====
// five register stages: differences, products, sums, case select and
// squaring of the cross product, then the root operands; uses psd_pkg
module psd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [psd_pkg::CoordW-1:0]    i_px,
    input  logic signed [psd_pkg::CoordW-1:0]    i_py,
    input  logic signed [psd_pkg::CoordW-1:0]    i_ax,
    input  logic signed [psd_pkg::CoordW-1:0]    i_ay,
    input  logic signed [psd_pkg::CoordW-1:0]    i_bx,
    input  logic signed [psd_pkg::CoordW-1:0]    i_by_coord,
    output psd_pkg::t_root_bus                   o_bus
);
    import psd_pkg::*;

    // stage 1: differences
    logic                    r_v1;
    logic signed [DiffW-1:0] r_pax, r_pay, r_pbx, r_pby, r_abx, r_aby;
    // stage 2: products
    logic                    r_v2;
    logic [SqW-3:0]          r_sa1, r_sa2, r_sb1, r_sb2, r_sc1, r_sc2;
    logic signed [SqW-1:0]   r_da1, r_da2, r_db1, r_db2, r_cr1, r_cr2;
    // stage 3: sums
    logic                    r_v3;
    logic [Len2W-1:0]        r_a2, r_b2, r_c2;
    logic signed [DotW-1:0]  r_dota, r_dotb, r_cr;
    // stage 4: decisions and cross product partials
    logic                    r_v4, r_zero, r_ep;
    logic [Len2W-1:0]        r_e2, r_c2d;
    logic [SqW-1:0]          r_hh, r_hl, r_ll;
    // stage 5
    t_root_bus               r_bus;

    logic [DiffW-2:0]        n_apx, n_apy, n_apbx, n_apby, n_abx, n_aby;
    logic                    n_near_a, n_dneg, n_degen;
    logic [DotW-1:0]         n_crabs_w;
    logic [CrAbsW-1:0]       n_crabs;
    logic [DiffW-1:0]        n_hi, n_lo;
    logic [RemW-1:0]         n_cr2;

    function automatic logic [DiffW-2:0] f_mag(input logic signed [DiffW-1:0] v);
        logic [DiffW-1:0] m;
        m = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
        return m[DiffW-2:0];
    endfunction

    always_comb begin
        n_apx  = f_mag(r_pax);
        n_apy  = f_mag(r_pay);
        n_apbx = f_mag(r_pbx);
        n_apby = f_mag(r_pby);
        n_abx  = f_mag(r_abx);
        n_aby  = f_mag(r_aby);
        n_degen  = (r_c2 == '0);
        n_near_a = (r_a2 < r_b2);
        n_dneg   = n_near_a ? r_dota[DotW-1] : r_dotb[DotW-1];
        n_crabs_w = r_cr[DotW-1] ? DotW'(-r_cr) : DotW'(r_cr);
        n_crabs  = n_crabs_w[CrAbsW-1:0];
        n_hi     = n_crabs[CrAbsW-1:DiffW];
        n_lo     = n_crabs[DiffW-1:0];
        n_cr2    = (RemW'(r_hh) << (2 * DiffW)) + (RemW'(r_hl) << (DiffW + 1))
                 + RemW'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pax <= DiffW'(i_px) - DiffW'(i_ax);
        r_pay <= DiffW'(i_py) - DiffW'(i_ay);
        r_pbx <= DiffW'(i_px) - DiffW'(i_bx);
        r_pby <= DiffW'(i_py) - DiffW'(i_by_coord);
        r_abx <= DiffW'(i_bx) - DiffW'(i_ax);
        r_aby <= DiffW'(i_by_coord) - DiffW'(i_ay);

        r_sa1 <= n_apx * n_apx;
        r_sa2 <= n_apy * n_apy;
        r_sb1 <= n_apbx * n_apbx;
        r_sb2 <= n_apby * n_apby;
        r_sc1 <= n_abx * n_abx;
        r_sc2 <= n_aby * n_aby;
        r_da1 <= r_pax * r_abx;
        r_da2 <= r_pay * r_aby;
        r_db1 <= r_pbx * r_abx;
        r_db2 <= r_pby * r_aby;
        r_cr1 <= r_abx * r_pay;
        r_cr2 <= r_aby * r_pax;

        r_a2   <= Len2W'(r_sa1) + Len2W'(r_sa2);
        r_b2   <= Len2W'(r_sb1) + Len2W'(r_sb2);
        r_c2   <= Len2W'(r_sc1) + Len2W'(r_sc2);
        r_dota <= DotW'(r_da1) + DotW'(r_da2);
        // dot at b uses the reversed segment direction
        r_dotb <= -(DotW'(r_db1) + DotW'(r_db2));
        r_cr   <= DotW'(r_cr1) - DotW'(r_cr2);

        r_zero <= (r_a2 == '0) || (r_b2 == '0);
        r_ep   <= n_degen || n_dneg;
        r_e2   <= n_near_a ? r_a2 : r_b2;
        r_c2d  <= r_c2;
        r_hh   <= n_hi * n_hi;
        r_hl   <= n_hi * n_lo;
        r_ll   <= n_lo * n_lo;

        // endpoint distance is a plain root: divisor one
        r_bus.y <= '0;
        r_bus.q <= '0;
        if (r_zero) begin
            r_bus.rem <= '0;
            r_bus.c   <= Len2W'(1);
        end else if (r_ep) begin
            r_bus.rem <= RemW'(r_e2);
            r_bus.c   <= Len2W'(1);
        end else begin
            r_bus.rem <= n_cr2;
            r_bus.c   <= r_c2d;
        end

        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= r_v4;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== hw/rtl/psd_root_step.sv =====
// one bit of q = largest value with q*q*c <= rem, one register stage
// keeps y = q*c so the trial term needs shifts only; uses psd_pkg
module psd_root_step #(
    parameter int unsigned Bit = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psd_pkg::t_root_bus i_bus,
    output psd_pkg::t_root_bus o_bus
);
    import psd_pkg::*;

    t_root_bus        r_bus;
    logic [RemW-1:0]  n_trial;
    logic             n_take;

    always_comb begin
        n_trial = (RemW'(i_bus.y) << (Bit + 1)) + (RemW'(i_bus.c) << (2 * Bit));
        n_take  = (i_bus.rem >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= i_bus.valid;
        end
        r_bus.c <= i_bus.c;
        if (n_take) begin
            r_bus.rem    <= i_bus.rem - n_trial;
            r_bus.y      <= i_bus.y + (YW'(i_bus.c) << Bit);
            r_bus.q      <= i_bus.q | (DistW'(1) << Bit);
        end else begin
            r_bus.rem    <= i_bus.rem;
            r_bus.y      <= i_bus.y;
            r_bus.q      <= i_bus.q;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== tb/sv/psd_checker.sv =====
// checker for point_segment_distance_core: predicts each distance and compares
// depends on psd_pkg for widths
`timescale 1ns / 100ps

module psd_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [psd_pkg::CoordW-1:0]    i_px,
    input  logic signed [psd_pkg::CoordW-1:0]    i_py,
    input  logic signed [psd_pkg::CoordW-1:0]    i_ax,
    input  logic signed [psd_pkg::CoordW-1:0]    i_ay,
    input  logic signed [psd_pkg::CoordW-1:0]    i_bx,
    input  logic signed [psd_pkg::CoordW-1:0]    i_by_coord,
    input  logic                                 o_valid,
    input  logic [psd_pkg::DistW-1:0]            o_distance,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    logic [psd_pkg::DistW-1:0] dist_queue[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 36;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // largest q with q*q*len2 <= cr*cr
    function automatic longint unsigned perp_dist(longint unsigned cr, longint unsigned len2);
        logic [127:0] lim, prod;
        longint unsigned q, t;
        lim = 128'(cr) * 128'(cr);
        q = 0;
        for (int k = 16; k >= 0; k--) begin
            t = q | (64'd1 << k);
            prod = 128'(t * t) * 128'(len2);
            if (prod <= lim) q = t;
        end
        return q;
    endfunction

    function automatic logic [psd_pkg::DistW-1:0] seg_distance(
        longint px, longint py, longint ax, longint ay, longint bx, longint by);
        longint pax, pay, pbx, pby, abx, aby, dot, cr;
        longint unsigned a2, b2, c2, d;
        pax = px - ax; pay = py - ay;
        pbx = px - bx; pby = py - by;
        abx = bx - ax; aby = by - ay;
        a2 = pax * pax + pay * pay;
        b2 = pbx * pbx + pby * pby;
        c2 = abx * abx + aby * aby;
        if (a2 == 0 || b2 == 0) begin
            d = 0;
        end else if (c2 == 0) begin
            d = int_sqrt(a2);
        end else begin
            if (a2 < b2) dot = pax * abx + pay * aby;
            else dot = -(pbx * abx + pby * aby);
            if (dot < 0) begin
                d = int_sqrt((a2 < b2) ? a2 : b2);
            end else begin
                cr = abx * pay - aby * pax;
                d = perp_dist((cr < 0) ? -cr : cr, c2);
            end
        end
        return d[psd_pkg::DistW-1:0];
    endfunction

    assign o_pending = dist_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        logic [psd_pkg::DistW-1:0] want;
        if (i_rst_n && start && !busy)
            dist_queue.push_back(seg_distance(i_px, i_py, i_ax, i_ay, i_bx, i_by_coord));
        if (i_rst_n && o_valid) begin
            if (dist_queue.size() == 0) begin
                if (o_fail_count < 10) $display("unexpected distance %0d", o_distance);
                o_fail_count++;
            end else begin
                want = dist_queue.pop_front();
                if (want !== o_distance) begin
                    if (o_fail_count < 10)
                        $display("distance mismatch: expected %0d got %0d", want, o_distance);
                    o_fail_count++;
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// stimulus and verdict for point_segment_distance_core
// depends on psd_pkg and psd_checker
`timescale 1ns / 100ps

module tb_top;
    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy, o_valid;
    logic signed [15:0] i_px = 0, i_py = 0, i_ax = 0, i_ay = 0, i_bx = 0, i_by_coord = 0;
    logic [psd_pkg::DistW-1:0] o_distance;
    int fail_count, pending;
    int cycles = 0;

    always #10 i_clk = ~i_clk;

    point_segment_distance_core DUT (.*);

    psd_checker checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(logic [15:0] px, py, ax, ay, bx, by, bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            start <= 0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge i_clk);
        end
        i_px <= px; i_py <= py; i_ax <= ax; i_ay <= ay; i_bx <= bx; i_by_coord <= by;
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] c[6];
        int m, wait_n;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: extremes, endpoint hits, degenerate segment, ties, right angle
        send(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 1);
        send(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 0);
        send(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send(16'd100, 16'd50, 16'd100, 16'd50, 16'd300, 16'd7, 0);
        send(16'd300, 16'd7, 16'd100, 16'd50, 16'd300, 16'd7, 1);
        send(16'd10, 16'd20, 16'd5, 16'd5, 16'd5, 16'd5, 0);
        send(16'd0, 16'd10, 16'hfff6, 16'd0, 16'd10, 16'd0, 0);
        send(16'd0, 16'd0, 16'hfff6, 16'd0, 16'd10, 16'd0, 0);
        send(16'd20, 16'd5, 16'd0, 16'd0, 16'd10, 16'd0, 1);
        send(16'hffec, 16'd5, 16'd0, 16'd0, 16'd10, 16'd0, 0);
        send(16'd10, 16'd7, 16'd0, 16'd0, 16'd10, 16'd0, 0);
        send(16'd0, 16'd7, 16'd0, 16'd0, 16'd10, 16'd0, 0);
        send(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8001, 0);
        send(16'hffff, 16'h0000, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 1);
        for (int n = 0; n < 500; n++) begin
            m = $urandom_range(0, 9);
            for (int k = 0; k < 6; k++)
                c[k] = rand_coord(m < 1 ? $urandom_range(0, 1) : (m < 4 ? 2 : 3));
            if (m == 4) begin c[0] = c[2]; c[1] = c[3]; end
            if (m == 5) begin c[4] = c[2]; c[5] = c[3]; end
            send(c[0], c[1], c[2], c[3], c[4], c[5], n < 420);
        end
        start <= 0;
        while (pending != 0) @(negedge i_clk);
        wait_n = psd_pkg::Latency + 10;
        repeat (wait_n) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/psd_pkg.sv
hw/rtl/psd_front.sv
hw/rtl/psd_root_step.sv
hw/rtl/point_segment_distance_core.sv
tb/sv/psd_checker.sv
tb/sv/tb_top.sv
